@@ rtl/fsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_pkg: shared definitions for the frame slot allocator
// Sizes, command and status codes, and the control/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package fsa_pkg;

	// Sizing
	localparam int SLOTS       = 1024;
	localparam int QUEUE_DEPTH = 16;
	localparam int SLOT_W      = 10;
	localparam int CMD_W       = 2;
	localparam int STAT_W      = 3;

	// Free map is kept as rows of WORD_W bits
	localparam int WORD_W  = 32;
	localparam int BIT_W   = $clog2(WORD_W);
	localparam int ROWS    = (SLOTS + WORD_W - 1) / WORD_W;
	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

	// Pending-free queue
	localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_ALLOCATED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_NONE_FREE  = 3'd1;
	localparam logic [STAT_W-1:0] ST_QUEUED     = 3'd2;
	localparam logic [STAT_W-1:0] ST_QUEUE_FULL = 3'd3;
	localparam logic [STAT_W-1:0] ST_RELEASED   = 3'd4;

	// Controller to datapath
	typedef struct packed {
		logic latch;      // capture frame field of accepted item
		logic alloc_none; // emit "none free"
		logic alloc_rd;   // pick lowest non-empty row, read it
		logic alloc_wr;   // claim lowest free bit, emit result
		logic clean;      // push frame or report full, emit result
		logic rel_rd;     // pop queue head, read its row
		logic rel_wr;     // set freed bit, emit result
	} fsa_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic any_free;
		logic queue_empty;
	} fsa_stat_t;

endpackage

@@ rtl/fsa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_ctrl: allocator sequencer
// Accepts one item at a time, steps through the read and write phases of the
// free map and queue, and owns the result valid flag.
// ----------------------------------------------------------------------------
module fsa_ctrl
	import fsa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [CMD_W-1:0] command,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output fsa_cmd_t         cmd,
	input  fsa_stat_t        stat
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_ALLOC_RD = 3'd1;
	localparam logic [2:0] S_ALLOC_WR = 3'd2;
	localparam logic [2:0] S_CLEAN    = 3'd3;
	localparam logic [2:0] S_REL_RD   = 3'd4;
	localparam logic [2:0] S_REL_WR   = 3'd5;

	logic [2:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       accept;
	logic       out_free;
	logic       emit;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.latch = 1'b1;
					case (command)
						CMD_ALLOC: state_d = S_ALLOC_RD;
						CMD_CLEAN: state_d = S_CLEAN;
						CMD_TICK:  state_d = stat.queue_empty ? S_IDLE : S_REL_RD;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC_RD: begin
				if (stat.any_free) begin
					cmd.alloc_rd = 1'b1;
					state_d      = S_ALLOC_WR;
				end else if (out_free) begin
					cmd.alloc_none = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_ALLOC_WR: begin
				if (out_free) begin
					cmd.alloc_wr = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_CLEAN: begin
				if (out_free) begin
					cmd.clean = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_REL_RD: begin
				cmd.rel_rd = 1'b1;
				state_d    = S_REL_WR;
			end
			S_REL_WR: begin
				if (out_free) begin
					cmd.rel_wr = 1'b1;
					state_d    = stat.queue_empty ? S_IDLE : S_REL_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign emit = cmd.alloc_none || cmd.alloc_wr || cmd.clean || cmd.rel_wr;

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/fsa_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_dpath: free map, pending-free queue and result register
// The free map is a row memory with a per-row valid bit and a per-row
// "has a free slot" summary; an unwritten row reads as all slots free.
// ----------------------------------------------------------------------------
module fsa_dpath
	import fsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  fsa_cmd_t          cmd,
	output fsa_stat_t         stat,
	input  logic [SLOT_W-1:0] frame,
	output logic [STAT_W-1:0] status,
	output logic [SLOT_W-1:0] slot,
	output logic              last
);

	// Lowest set bit of the row summary
	function automatic logic [ROW_W-1:0] low_row(input logic [ROWS-1:0] v);
		logic [ROW_W-1:0] idx;
		idx = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (v[i]) idx = ROW_W'(i);
		end
		return idx;
	endfunction

	// Lowest set bit of one row
	function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

	// Reset content of a row: ones for slots that exist
	function automatic logic [WORD_W-1:0] row_init(input logic [ROW_W-1:0] r);
		logic [WORD_W-1:0] m;
		for (int b = 0; b < WORD_W; b++) begin
			m[b] = ((int'(r) * WORD_W + b) < SLOTS);
		end
		return m;
	endfunction

	logic [WORD_W-1:0] free_mem [ROWS];
	logic [WORD_W-1:0] rd_q;
	logic [ROWS-1:0]   row_valid_q;
	logic [ROWS-1:0]   summary_q;
	logic [ROW_W-1:0]  row_q;

	logic [SLOT_W-1:0] queue_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0] head_q;
	logic [QCNT_W-1:0] count_q;
	logic [SLOT_W-1:0] frame_q;
	logic [SLOT_W-1:0] rel_slot_q;
	logic              rel_in_q;

	logic [STAT_W-1:0] status_q;
	logic [SLOT_W-1:0] slot_q;
	logic              last_q;

	logic [ROW_W-1:0]  sel_row;
	logic [SLOT_W-1:0] head_slot;
	logic              head_in;
	logic [ROW_W-1:0]  head_row;
	logic [ROW_W-1:0]  rd_row;
	logic              rd_en;
	logic [WORD_W-1:0] word_eff;
	logic [BIT_W-1:0]  alloc_bit;
	logic [WORD_W-1:0] alloc_word;
	logic [WORD_W-1:0] rel_word;
	logic              wr_en;
	logic [WORD_W-1:0] wr_word;
	logic              q_full;
	logic [QIDX_W:0]   tail_sum;
	logic [QIDX_W-1:0] tail;
	logic [QIDX_W-1:0] head_inc;
	logic              load_out;
	logic [STAT_W-1:0] status_d;
	logic [SLOT_W-1:0] slot_d;
	logic              last_d;

	// Row selection and read address
	assign sel_row   = low_row(summary_q);
	assign head_slot = queue_q[head_q];
	assign head_in   = ({{(32 - SLOT_W){1'b0}}, head_slot} < 32'(SLOTS));
	assign head_row  = head_in ? ROW_W'(head_slot >> BIT_W) : '0;
	assign rd_row    = cmd.alloc_rd ? sel_row : head_row;
	assign rd_en     = cmd.alloc_rd || cmd.rel_rd;

	// Row as read back, with reset content for rows never written
	assign word_eff   = row_valid_q[row_q] ? rd_q : row_init(row_q);
	assign alloc_bit  = low_bit(word_eff);
	assign alloc_word = word_eff & ~(WORD_W'(1) << alloc_bit);
	assign rel_word   = word_eff | (WORD_W'(1) << rel_slot_q[BIT_W-1:0]);
	assign wr_en      = cmd.alloc_wr || (cmd.rel_wr && rel_in_q);
	assign wr_word    = cmd.alloc_wr ? alloc_word : rel_word;

	// Free map memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			free_mem[row_q] <= wr_word;
		end
		if (rd_en) begin
			rd_q <= free_mem[rd_row];
		end
	end

	// Row address and release slot capture
	always_ff @(posedge clk) begin
		if (cmd.alloc_rd) begin
			row_q <= sel_row;
		end else if (cmd.rel_rd) begin
			row_q      <= head_row;
			rel_slot_q <= head_slot;
			rel_in_q   <= head_in;
		end
		if (cmd.latch) begin
			frame_q <= frame;
		end
	end

	// Row valid bits and free summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			summary_q   <= '1;
		end else if (wr_en) begin
			row_valid_q[row_q] <= 1'b1;
			summary_q[row_q]   <= |wr_word;
		end
	end

	// Queue pointers
	assign q_full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign tail_sum = {1'b0, head_q} + (QIDX_W + 1)'(count_q);
	assign tail     = (tail_sum >= (QIDX_W + 1)'(QUEUE_DEPTH)) ?
		QIDX_W'(tail_sum - (QIDX_W + 1)'(QUEUE_DEPTH)) : QIDX_W'(tail_sum);
	assign head_inc = ({1'b0, head_q} + 1'b1 >= (QIDX_W + 1)'(QUEUE_DEPTH)) ?
		'0 : head_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.clean && !q_full) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.rel_rd) begin
			head_q  <= head_inc;
			count_q <= count_q - 1'b1;
		end
	end

	// Queue entries
	always_ff @(posedge clk) begin
		if (cmd.clean && !q_full) begin
			queue_q[tail] <= frame_q;
		end
	end

	// Result selection
	always_comb begin
		status_d = ST_NONE_FREE;
		slot_d   = '0;
		last_d   = 1'b1;
		if (cmd.alloc_wr) begin
			status_d = ST_ALLOCATED;
			slot_d   = SLOT_W'({row_q, alloc_bit});
		end else if (cmd.clean) begin
			status_d = q_full ? ST_QUEUE_FULL : ST_QUEUED;
			slot_d   = q_full ? '0 : frame_q;
		end else if (cmd.rel_wr) begin
			status_d = ST_RELEASED;
			slot_d   = rel_slot_q;
			last_d   = (count_q == '0);
		end
	end

	assign load_out = cmd.alloc_none || cmd.alloc_wr || cmd.clean || cmd.rel_wr;

	// Result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= status_d;
			slot_q   <= slot_d;
			last_q   <= last_d;
		end
	end

	assign status = status_q;
	assign slot   = slot_q;
	assign last   = last_q;

	// Status back to the sequencer
	always_comb begin
		stat.any_free    = |summary_q;
		stat.queue_empty = (count_q == '0);
	end

endmodule

@@ rtl/frame_slot_allocator_deferred_free.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_slot_allocator_deferred_free: lowest-free slot allocator
// Hands out the lowest free frame-list slot, queues slots for deferred
// release and frees the whole queue on a tick, one result per slot.
//
//   channel  handshake              fields
//   req      req_valid / req_stall  command[1:0], frame[9:0]
//   rsp      rsp_valid / rsp_stall  status[2:0], slot[9:0], last
//
// Allocate has a row read and a row write phase (just a report if none is free),
// clean one push phase, tick a read and a write phase per queued slot; the
// read-modify-write of one free-map row per allocate or release sets this.
// Results leave through a register, so the next item is taken while the last
// result waits; a stalled result holds the sequencer at its write phase.
// No clearing pass after reset: per-row valid bits make unwritten rows free.
// ----------------------------------------------------------------------------
module frame_slot_allocator_deferred_free
	import fsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [SLOT_W-1:0] frame,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [STAT_W-1:0] status,
	output logic [SLOT_W-1:0] slot,
	output logic              last
);

	fsa_cmd_t  cmd;
	fsa_stat_t stat;

	// Sequencer
	fsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.command   (command),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Free map, queue and result register
	fsa_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.frame  (frame),
		.status (status),
		.slot   (slot),
		.last   (last)
	);

endmodule
